/* rtl/core/arpc_pkg.sv */
`timescale 1ns / 1ps

package arpc_pkg;

	// Number of table slots and the width of a slot index.
	localparam int CACHE_ENTRIES = 16;
	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [31:0] ip_t;
	typedef logic [47:0] mac_t;

	localparam idx_t LAST_IDX = idx_t'(CACHE_ENTRIES - 1);

	// Operation selector codes.
	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP = 2'd1;
	localparam logic [1:0] FUNC_PACKET = 2'd2;

	// Configuration register indexes.
	localparam logic REG_OWN_IP  = 1'b0;
	localparam logic REG_OWN_MAC = 1'b1;

	// ARP field values that a valid Ethernet/IPv4 packet must carry, and the request operation code.
	localparam logic [15:0] ARP_MIN_LEN   = 16'd28;
	localparam logic [15:0] ARP_HW_ETH    = 16'h0001;
	localparam logic [15:0] ARP_PROTO_IP4 = 16'h0800;
	localparam logic [7:0]  ARP_HW_LEN    = 8'd6;
	localparam logic [7:0]  ARP_PROTO_LEN = 8'd4;
	localparam logic [15:0] ARP_OP_REQ    = 16'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} arpc_state_t;

	// Table write request from the sequencer.
	typedef struct packed {
		logic en;
		idx_t addr;
		ip_t  ip;
		mac_t mac;
	} arpc_wr_t;

endpackage

/* rtl/core/arpc_table.sv */
`timescale 1ns / 1ps

module arpc_table (
	input  logic              clk,
	input  logic              arst_n,
	input  arpc_pkg::idx_t    rd_addr,
	input  arpc_pkg::ip_t     key,
	input  arpc_pkg::arpc_wr_t wr,
	output logic              match,
	output arpc_pkg::mac_t    rd_mac_s1
);
	import arpc_pkg::*;

	ip_t  ip_mem  [CACHE_ENTRIES];
	mac_t mac_mem [CACHE_ENTRIES];
	logic [CACHE_ENTRIES-1:0] valid_q;

	ip_t  rd_ip_s1;
	logic rd_valid_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			ip_mem[wr.addr]  <= wr.ip;
			mac_mem[wr.addr] <= wr.mac;
		end
		rd_ip_s1  <= ip_mem[rd_addr];
		rd_mac_s1 <= mac_mem[rd_addr];
	end

	// Valid marks live in flip-flops so that reset empties the table at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			rd_valid_s1 <= valid_q[rd_addr];
		end
	end

	// The one shared comparator: the registered slot against the search key.
	assign match = rd_valid_s1 && (rd_ip_s1 == key);

endmodule

/* rtl/core/arp_cache_and_responder.sv */
`timescale 1ns / 1ps
// An add, a lookup or a learning packet goes through the table scan, one slot per cycle, before
// its result is made; other items go straight to the result stage.
// The block works on one item at a time.
// A new item may be taken while the previous result still waits in the output register.
// Reset (arst_n low, asynchronous) empties the table, clears the round-robin pointer and
// our own IP register, and drops any pending result.

module arp_cache_and_responder (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [47:0] cfg_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [31:0] ip_addr,
	input  logic [47:0] mac_addr,
	input  logic [31:0] tgt_ip,
	input  logic [15:0] arp_oper,
	input  logic [15:0] hw_type,
	input  logic [15:0] proto_type,
	input  logic [7:0]  hw_len,
	input  logic [7:0]  proto_len,
	input  logic [15:0] pkt_length,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [47:0] found_mac,
	output logic        packet_accepted,
	output logic        reply_valid,
	output logic [47:0] reply_dest_mac,
	output logic [31:0] reply_target_ip
);
	import arpc_pkg::*;

	// Control state.
	arpc_state_t state_q, state_d;
	logic        out_valid_q;
	idx_t        next_slot_q;
	logic        chk_q;
	ip_t         own_ip_q;

	// The item being worked on, held from its input transfer to its result.
	ip_t  ip_q;
	mac_t mac_q;
	logic learn_q;
	logic lookup_q;
	logic res_acc_q;
	logic res_reply_q;
	logic res_found_q;
	mac_t res_mac_q;

	// Scan pointers: idx_q is the slot being read, chk_idx_q the slot now compared.
	idx_t idx_q;
	idx_t chk_idx_q;

	// Output register.
	logic found_q;
	mac_t found_mac_q;
	logic acc_out_q;
	logic reply_out_q;
	mac_t reply_mac_q;
	ip_t  reply_ip_q;

	logic     accept;
	logic     pkt_ok;
	logic     needs_scan;
	logic     match;
	mac_t     rd_mac_s1;
	logic     scan_hit;
	logic     scan_miss;
	logic     out_free;
	logic     out_load;
	arpc_wr_t wr;

	arpc_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_addr   (idx_q),
		.key       (ip_q),
		.wr        (wr),
		.match     (match),
		.rd_mac_s1 (rd_mac_s1)
	);

	// The packet checks are evaluated on the input fields during the transfer cycle.
	assign pkt_ok = (pkt_length >= ARP_MIN_LEN) && (hw_type == ARP_HW_ETH) &&
		(proto_type == ARP_PROTO_IP4) && (hw_len == ARP_HW_LEN) &&
		(proto_len == ARP_PROTO_LEN);

	// Adds and lookups always scan; a packet scans only when it will be learned.
	// A zero sender address is never learned, and the unused selector does nothing.
	assign needs_scan = (func == FUNC_ADD) || (func == FUNC_LOOKUP) ||
		((func == FUNC_PACKET) && pkt_ok && (ip_addr != '0));

	// The scan stops at the first matching slot, so the lowest index wins. A miss is
	// known once the last slot has been compared.
	assign scan_hit  = (state_q == ST_SCAN) && chk_q && match;
	assign scan_miss = (state_q == ST_SCAN) && chk_q && !match && (chk_idx_q == LAST_IDX);

	// A learn updates the hit slot in place, or else takes the round-robin slot.
	always_comb begin
		wr.en   = (scan_hit || scan_miss) && learn_q;
		wr.addr = scan_hit ? chk_idx_q : next_slot_q;
		wr.ip   = ip_q;
		wr.mac  = mac_q;
	end

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		accept   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
				if (in_valid) begin
					state_d = needs_scan ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (scan_hit || scan_miss) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// The result waits here until the output register can take it.
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			next_slot_q <= '0;
			chk_q       <= 1'b0;
			own_ip_q    <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (wr.en && scan_miss) begin
				next_slot_q <= (next_slot_q == LAST_IDX) ? '0 : next_slot_q + idx_t'(1);
			end
			if (accept) begin
				chk_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				chk_q <= 1'b1;
			end
			// The local MAC is only the sender address of a reply frame, which is built
			// outside this block, so it is not kept here.
			if (cfg_we && (cfg_index == REG_OWN_IP)) begin
				own_ip_q <= cfg_data[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ip_q        <= ip_addr;
			mac_q       <= mac_addr;
			learn_q     <= func != FUNC_LOOKUP;
			lookup_q    <= func == FUNC_LOOKUP;
			res_acc_q   <= (func == FUNC_PACKET) && pkt_ok;
			res_reply_q <= (func == FUNC_PACKET) && pkt_ok && (arp_oper == ARP_OP_REQ) &&
				(tgt_ip == own_ip_q);
			res_found_q <= 1'b0;
			res_mac_q   <= '0;
			idx_q       <= '0;
			chk_idx_q   <= '0;
		end else if (state_q == ST_SCAN) begin
			if (idx_q != LAST_IDX) begin
				idx_q <= idx_q + idx_t'(1);
			end
			chk_idx_q <= idx_q;
			if (scan_hit && lookup_q) begin
				res_found_q <= 1'b1;
				res_mac_q   <= rd_mac_s1;
			end
		end
		if (out_load) begin
			found_q     <= res_found_q;
			found_mac_q <= res_mac_q;
			acc_out_q   <= res_acc_q;
			reply_out_q <= res_reply_q;
			reply_mac_q <= res_reply_q ? mac_q : '0;
			reply_ip_q  <= res_reply_q ? ip_q : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign found           = found_q;
	assign found_mac       = found_mac_q;
	assign packet_accepted = acc_out_q;
	assign reply_valid     = reply_out_q;
	assign reply_dest_mac  = reply_mac_q;
	assign reply_target_ip = reply_ip_q;

	// A table write only happens on the cycle the scan reaches its decision.
	a_write_at_decision: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == ST_SCAN) && chk_q && !lookup_q)
		else $error("table write outside a scan decision");

	// The round-robin pointer never leaves the table.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		next_slot_q <= LAST_IDX)
		else $error("next slot out of range");

	// A lookup hit and a packet result never come together.
	a_found_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> !packet_accepted && !reply_valid)
		else $error("lookup hit mixed with packet result");

	// A reply is only ever made for an accepted packet.
	a_reply_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reply_valid |-> packet_accepted)
		else $error("reply without accepted packet");

	// A result is loaded only into a free output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || !out_stall)
		else $error("pending result overwritten");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import arpc_pkg::*;

	// The selector value that no operation uses, and the ARP reply code.
	localparam logic [1:0]  FUNC_UNUSED  = 2'd3;
	localparam logic [15:0] ARP_OP_REPLY = 16'd2;

	localparam int RANDOM_PHASES    = 6;
	localparam int PHASE_ITEMS      = 215;
	localparam int POOL_SIZE        = 24;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES     = 2 * CACHE_ENTRIES + 8;
	localparam int MAX_REPORTS      = 10;

	// One operation as it crosses the input channel.
	typedef struct packed {
		logic [1:0]  func;
		ip_t         ip;
		mac_t        mac;
		ip_t         tip;
		logic [15:0] oper;
		logic [15:0] htype;
		logic [15:0] ptype;
		logic [7:0]  hlen;
		logic [7:0]  plen;
		logic [15:0] len;
	} arp_req_t;

	// One result as it crosses the output channel.
	typedef struct packed {
		logic found;
		mac_t found_mac;
		logic accepted;
		logic reply;
		mac_t reply_mac;
		ip_t  reply_ip;
	} arp_rsp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_OWN_IP;
	logic [47:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = FUNC_ADD;
	logic [31:0] ip_addr = '0;
	logic [47:0] mac_addr = '0;
	logic [31:0] tgt_ip = '0;
	logic [15:0] arp_oper = '0;
	logic [15:0] hw_type = '0;
	logic [15:0] proto_type = '0;
	logic [7:0]  hw_len = '0;
	logic [7:0]  proto_len = '0;
	logic [15:0] pkt_length = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        found;
	logic [47:0] found_mac;
	logic        packet_accepted;
	logic        reply_valid;
	logic [47:0] reply_dest_mac;
	logic [31:0] reply_target_ip;

	arp_cache_and_responder u_dut (.*);

	// The period is 20 ns: 10 ns low, then 10 ns high.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Our own copy of the address table and the two registers. It is advanced once
	// per accepted input transfer, in transfer order, so it always reflects the table
	// as the block will see it when it starts on that operation.
	ip_t  tbl_ip [CACHE_ENTRIES];
	mac_t tbl_mac [CACHE_ENTRIES];
	logic tbl_valid [CACHE_ENTRIES];
	idx_t tbl_next;
	ip_t  pred_own_ip;
	mac_t pred_own_mac;

	// Operations waiting to be sent, and the results the table copy says must come back.
	arp_req_t req_q [$];
	arp_rsp_t predicted_rsp_q [$];
	arp_req_t held_req;

	// A small set of addresses, so that lookups hit, adds overwrite in place, and the
	// round-robin pointer wraps and evicts once more than CACHE_ENTRIES names circulate.
	ip_t ip_pool [POOL_SIZE];

	int   queued_cnt = 0;
	int   accepted_cnt = 0;
	int   result_cnt = 0;
	int   fail_cnt = 0;
	int   send_gap = 0;
	int   stall_left = 0;
	logic idling_on = 1'b1;
	logic long_hold = 1'b0;
	logic hold_request = 1'b0;

	function automatic int find_entry(ip_t a);
		int i;
		for (i = 0; i < CACHE_ENTRIES; i++)
			if (tbl_valid[i] && tbl_ip[i] == a)
				return i;
		return -1;
	endfunction

	// A known address gets its MAC replaced where it sits; a new one takes the slot
	// under the round-robin pointer, whatever that slot held before.
	function automatic void learn_mapping(ip_t a, mac_t m);
		int hit;
		hit = find_entry(a);
		if (hit >= 0) begin
			tbl_mac[hit] = m;
		end else begin
			tbl_ip[tbl_next] = a;
			tbl_mac[tbl_next] = m;
			tbl_valid[tbl_next] = 1'b1;
			tbl_next = (tbl_next == LAST_IDX) ? idx_t'(0) : tbl_next + idx_t'(1);
		end
	endfunction

	function automatic arp_rsp_t predict_arp(arp_req_t r);
		arp_rsp_t rsp;
		int hit;
		rsp = '0;
		case (r.func)
		FUNC_ADD: begin
			learn_mapping(r.ip, r.mac);
		end
		FUNC_LOOKUP: begin
			hit = find_entry(r.ip);
			if (hit >= 0) begin
				rsp.found = 1'b1;
				rsp.found_mac = tbl_mac[hit];
			end
		end
		FUNC_PACKET: begin
			if (r.len >= ARP_MIN_LEN && r.htype == ARP_HW_ETH && r.ptype == ARP_PROTO_IP4 &&
					r.hlen == ARP_HW_LEN && r.plen == ARP_PROTO_LEN) begin
				rsp.accepted = 1'b1;
				// A sender of 0.0.0.0 is a probe: never learned, but still answered if it asks for our IP.
				if (r.ip != '0)
					learn_mapping(r.ip, r.mac);
				if (r.oper == ARP_OP_REQ && r.tip == pred_own_ip) begin
					rsp.reply = 1'b1;
					rsp.reply_mac = r.mac;
					rsp.reply_ip = r.ip;
				end
			end
		end
		default: begin
		end
		endcase
		return rsp;
	endfunction

	function automatic ip_t pick_ip();
		if ($urandom_range(0, 99) < 85)
			return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
		return ip_t'($urandom);
	endfunction

	function automatic mac_t random_mac();
		return mac_t'({$urandom, $urandom});
	endfunction

	function automatic arp_req_t good_pkt(ip_t sender, mac_t sender_mac, ip_t target,
			logic [15:0] op);
		arp_req_t r;
		r.func = FUNC_PACKET;
		r.ip = sender;
		r.mac = sender_mac;
		r.tip = target;
		r.oper = op;
		r.htype = ARP_HW_ETH;
		r.ptype = ARP_PROTO_IP4;
		r.hlen = ARP_HW_LEN;
		r.plen = ARP_PROTO_LEN;
		r.len = ARP_MIN_LEN;
		return r;
	endfunction

	function automatic arp_req_t table_req(logic [1:0] f, ip_t a, mac_t m);
		arp_req_t r;
		r = '0;
		r.func = f;
		r.ip = a;
		r.mac = m;
		return r;
	endfunction

	// Every field starts as raw random bits, so each bit of each field is seen both
	// ways. Three packets in four are then made well-formed so they get past the checks
	// into learning and answering; the rest break exactly one check.
	function automatic arp_req_t random_req();
		arp_req_t r;
		int roll;
		roll = $urandom_range(0, 99);
		r.func = (roll < 25) ? FUNC_ADD : (roll < 55) ? FUNC_LOOKUP :
			(roll < 95) ? FUNC_PACKET : FUNC_UNUSED;
		r.ip = pick_ip();
		r.mac = random_mac();
		r.tip = ip_t'($urandom);
		r.oper = 16'($urandom);
		r.htype = 16'($urandom);
		r.ptype = 16'($urandom);
		r.hlen = 8'($urandom);
		r.plen = 8'($urandom);
		r.len = 16'($urandom);
		if (r.func == FUNC_PACKET) begin
			roll = $urandom_range(0, 99);
			if (roll < 50)
				r.tip = pred_own_ip;
			else if (roll < 75)
				r.tip = pick_ip();
			roll = $urandom_range(0, 99);
			if (roll < 70)
				r.oper = ARP_OP_REQ;
			else if (roll < 90)
				r.oper = ARP_OP_REPLY;
			r.htype = ARP_HW_ETH;
			r.ptype = ARP_PROTO_IP4;
			r.hlen = ARP_HW_LEN;
			r.plen = ARP_PROTO_LEN;
			if ($urandom_range(0, 7) == 0)
				r.len = 16'($urandom_range(ARP_MIN_LEN, 16'hFFFF));
			else
				r.len = 16'($urandom_range(ARP_MIN_LEN, 96));
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 4))
				0: r.len = 16'($urandom_range(0, ARP_MIN_LEN - 1));
				1: r.htype = 16'($urandom);
				2: r.ptype = 16'($urandom);
				3: r.hlen = 8'($urandom);
				default: r.plen = 8'($urandom);
				endcase
			end
		end
		return r;
	endfunction

	task automatic push_req(arp_req_t r);
		req_q.push_back(r);
		queued_cnt++;
	endtask

	// Register writes only happen while the block is idle, so the table copy can take
	// the new value at once.
	task automatic write_reg(logic idx, mac_t value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_OWN_IP)
			pred_own_ip = ip_t'(value);
		else
			pred_own_mac = value;
	endtask

	// Every operation yields exactly one result, so the block is idle once everything
	// queued has been taken and every predicted result has come back.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (accepted_cnt != queued_cnt || predicted_rsp_q.size() != 0);
	endtask

	// Sender. A transfer that is offered stays put until it is taken. Between
	// transfers, idle gaps of random length are inserted while idling is on.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predicted_rsp_q.push_back(predict_arp(held_req));
				accepted_cnt++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (idling_on && $urandom_range(0, 7) == 0) begin
					send_gap <= $urandom_range(0, 17);
					in_valid <= 1'b0;
				end else if (req_q.size() != 0) begin
					held_req = req_q.pop_front();
					in_valid <= 1'b1;
					func <= held_req.func;
					ip_addr <= held_req.ip;
					mac_addr <= held_req.mac;
					tgt_ip <= held_req.tip;
					arp_oper <= held_req.oper;
					hw_type <= held_req.htype;
					proto_type <= held_req.ptype;
					hw_len <= held_req.hlen;
					proto_len <= held_req.plen;
					pkt_length <= held_req.len;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver. Each result transfer is checked against the oldest prediction. The
	// stall comes in bursts of random length, or holds for as long as the
	// long hold-off is in force.
	always @(posedge clk) begin
		arp_rsp_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				result_cnt++;
				if (predicted_rsp_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= MAX_REPORTS)
						$display("result %0d arrived with no result expected", result_cnt);
				end else begin
					want = predicted_rsp_q.pop_front();
					if (found !== want.found || found_mac !== want.found_mac ||
							packet_accepted !== want.accepted || reply_valid !== want.reply ||
							reply_dest_mac !== want.reply_mac ||
							reply_target_ip !== want.reply_ip) begin
						fail_cnt++;
						if (fail_cnt <= MAX_REPORTS) begin
							$display("result %0d expected: found=%b mac=%h acc=%b reply=%b dst=%h ip=%h",
								result_cnt, want.found, want.found_mac, want.accepted,
								want.reply, want.reply_mac, want.reply_ip);
							$display("result %0d actual:   found=%b mac=%h acc=%b reply=%b dst=%h ip=%h",
								result_cnt, found, found_mac, packet_accepted,
								reply_valid, reply_dest_mac, reply_target_ip);
						end
					end
				end
			end
			if (long_hold) begin
				out_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 17);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// The long hold-off runs in a process of its own. While it lasts the sender keeps
	// offering, so the block's result register and its work slot both fill up and the
	// input channel has to stall.
	initial begin
		wait (hold_request);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (LONG_HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		arp_req_t r;
		ip_t home_ip;
		int i;
		int p;
		int n;

		for (i = 0; i < CACHE_ENTRIES; i++) begin
			tbl_ip[i] = '0;
			tbl_mac[i] = '0;
			tbl_valid[i] = 1'b0;
		end
		tbl_next = '0;
		pred_own_ip = '0;
		pred_own_mac = '0;
		ip_pool[0] = '0;
		ip_pool[1] = '1;
		for (i = 2; i < POOL_SIZE; i++)
			ip_pool[i] = {8'd10, 8'($urandom), 8'd0, 8'(i)};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		home_ip = 32'hC0A8_0101;
		write_reg(REG_OWN_IP, mac_t'(home_ip));
		write_reg(REG_OWN_MAC, random_mac());

		// Directed opening. The table starts empty, and its zero IPs must not match.
		push_req(table_req(FUNC_LOOKUP, '0, '0));
		push_req(table_req(FUNC_ADD, '1, '1));
		push_req(table_req(FUNC_ADD, '0, 48'h0000_0000_0001));
		push_req(table_req(FUNC_LOOKUP, '1, '0));
		// The same address again must overwrite in place, not take a new slot.
		push_req(table_req(FUNC_ADD, '1, 48'h8000_0000_0000));
		push_req(table_req(FUNC_LOOKUP, '1, '0));
		// An unused selector with a perfectly good packet attached does nothing.
		r = good_pkt('1, '1, home_ip, ARP_OP_REQ);
		r.func = FUNC_UNUSED;
		push_req(r);
		push_req(good_pkt(32'h0A00_0001, 48'h0200_0000_0001, home_ip, ARP_OP_REQ));
		// A probe from 0.0.0.0 is answered; the lookup shows the add's MAC survived.
		push_req(good_pkt('0, 48'h0200_0000_0002, home_ip, ARP_OP_REQ));
		push_req(table_req(FUNC_LOOKUP, '0, '0));
		// Replies and unknown operation codes are learned from but not answered.
		push_req(good_pkt(32'h0A00_0002, 48'h0200_0000_0003, home_ip, ARP_OP_REPLY));
		push_req(good_pkt(32'h0A00_0003, 48'h0200_0000_0004, home_ip, 16'hFFFF));
		// A request for someone else still refreshes the sender's entry.
		push_req(good_pkt(32'h0A00_0001, 48'h0200_0000_0005, 32'h0A00_00FE, ARP_OP_REQ));
		push_req(table_req(FUNC_LOOKUP, 32'h0A00_0001, '0));
		// One packet per check, each breaking just that check, and one at the largest
		// length, which passes; the last sits exactly at the minimum length and passes.
		for (n = 0; n < 7; n++) begin
			r = good_pkt(32'h0A00_0009, mac_t'(n + 1), home_ip, ARP_OP_REQ);
			case (n)
			0: r.len = ARP_MIN_LEN - 16'd1;
			1: r.len = '1;
			2: r.htype = '0;
			3: r.ptype = 16'h0806;
			4: r.hlen = ARP_HW_LEN - 8'd1;
			5: r.plen = '1;
			default: begin
			end
			endcase
			push_req(r);
		end
		push_req(table_req(FUNC_LOOKUP, 32'h0A00_0009, '0));

		// Random phases, each under its own register setting. The table is kept from
		// one phase to the next. The sender waits for every result before each switch.
		for (p = 0; p < RANDOM_PHASES; p++) begin
			wait_drained();
			case (p)
			0: begin
				write_reg(REG_OWN_IP, '0);
				write_reg(REG_OWN_MAC, '0);
			end
			1: begin
				write_reg(REG_OWN_IP, '1);
				write_reg(REG_OWN_MAC, '1);
				hold_request = 1'b1;
			end
			default: begin
				write_reg(REG_OWN_IP, mac_t'(pick_ip()));
				write_reg(REG_OWN_MAC, random_mac());
			end
			endcase
			// The closing phase runs at full speed on both channels.
			if (p == RANDOM_PHASES - 1)
				idling_on <= 1'b0;
			for (n = 0; n < PHASE_ITEMS; n++)
				push_req(random_req());
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog: ends the run with an error long after the slowest correct run would finish.
	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* arp_cache_and_responder.f */
rtl/core/arpc_pkg.sv
rtl/core/arpc_table.sv
rtl/core/arp_cache_and_responder.sv
tb/tb_top.sv
